>>> hw/rtl/ertp_pkg.sv
// shared types, constants and tables for the euler rotate/translate point block
`default_nettype none
package ertp_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int ANGLE_W           = 17;
  localparam int COORD_W           = 32;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int MID_DEPTH         = 4;
  localparam int OUT_DEPTH         = 4;
  localparam int MSTEP_LAST        = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROLL,
    REG_PITCH,
    REG_HEADING,
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z
  } cfg_reg_t;

  typedef logic [8:0][31:0] coeff_mat_t;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic               sat;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } result_t;

  typedef enum logic [2:0] {
    BLD_IDLE,
    BLD_REDUCE,
    BLD_ROT,
    BLD_MAP,
    BLD_MUL,
    BLD_ACC
  } bld_state_t;

  // matrix sequencer operands and step kinds
  typedef enum logic [3:0] {
    OP_CP, OP_SP, OP_CO, OP_SO, OP_CK, OP_SK, OP_T1, OP_T2, OP_ONE
  } opnd_t;

  typedef enum logic [1:0] {
    MK_TMP,   // keep the product as an intermediate term
    MK_LOAD,  // first term of a two-term entry
    MK_SUM,   // second term, write clamped sum to the matrix
    MK_ONE    // single-term entry, write clamped product
  } mkind_t;

  typedef struct packed {
    mkind_t     kind;
    opnd_t      a;
    opnd_t      b;
    logic       neg;
    logic [3:0] dst;
  } mstep_t;

  function automatic mstep_t mstep(input logic [3:0] s);
    mstep_t m;
    case (s)
      4'd0:    m = '{MK_TMP,  OP_SP, OP_SO, 1'b0, 4'd0};
      4'd1:    m = '{MK_LOAD, OP_CP, OP_CK, 1'b0, 4'd0};
      4'd2:    m = '{MK_SUM,  OP_T1, OP_SK, 1'b1, 4'd0};
      4'd3:    m = '{MK_LOAD, OP_CP, OP_SK, 1'b1, 4'd1};
      4'd4:    m = '{MK_SUM,  OP_T1, OP_CK, 1'b1, 4'd1};
      4'd5:    m = '{MK_ONE,  OP_SP, OP_CO, 1'b1, 4'd2};
      4'd6:    m = '{MK_ONE,  OP_CO, OP_SK, 1'b0, 4'd3};
      4'd7:    m = '{MK_ONE,  OP_CO, OP_CK, 1'b0, 4'd4};
      4'd8:    m = '{MK_ONE,  OP_SO, OP_ONE, 1'b1, 4'd5};
      4'd9:    m = '{MK_TMP,  OP_CP, OP_SO, 1'b0, 4'd1};
      4'd10:   m = '{MK_LOAD, OP_SP, OP_CK, 1'b0, 4'd6};
      4'd11:   m = '{MK_SUM,  OP_T2, OP_SK, 1'b0, 4'd6};
      4'd12:   m = '{MK_LOAD, OP_SP, OP_SK, 1'b1, 4'd7};
      4'd13:   m = '{MK_SUM,  OP_T2, OP_CK, 1'b0, 4'd7};
      default: m = '{MK_ONE,  OP_CP, OP_CO, 1'b0, 4'd8};
    endcase
    return m;
  endfunction

  // truncated q30 atan(2^-i)
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      5'd24:   v = 32'h0000003F;
      5'd25:   v = 32'h0000001F;
      5'd26:   v = 32'h0000000F;
      5'd27:   v = 32'h00000008;
      5'd28:   v = 32'h00000004;
      5'd29:   v = 32'h00000002;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ertp_fifo.sv
// small first-word-fall-through queue
`default_nettype none
module ertp_fifo
  import ertp_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           din,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           dout,
  output logic                            empty,
  output logic                            full,
  output logic      [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic             do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/ertp_build.sv
// angle registers, shared cordic and sequential rotation matrix builder
`default_nettype none
module ertp_build
  import ertp_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output coeff_mat_t                 coeffs,
  output logic                       current
);
  localparam int IW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam logic signed [31:0] ONE  = 32'sd1073741824;
  localparam logic signed [33:0] GAIN = 34'sd652032874;
  localparam logic [1:0] ANG_HEAD = 2'd2;

  bld_state_t state, state_next;

  logic signed [ANGLE_W-1:0] roll, pitch, heading;
  logic [1:0]                ang_sel;
  logic [IW-1:0]             iter;
  logic [3:0]                step;
  logic [1:0]                quad;
  logic signed [33:0]        x, y;
  logic signed [32:0]        z;
  logic [31:0]               cosv [3];
  logic [31:0]               sinv [3];
  logic signed [31:0]        t1, t2;
  logic signed [32:0]        prod;
  logic signed [33:0]        acc;
  logic                      angle_wr;

  assign angle_wr = wr_en && (wr_index == REG_ROLL || wr_index == REG_PITCH ||
                              wr_index == REG_HEADING);

  function automatic logic [31:0] clamp30(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd1073741824) begin
      r = 32'h4000_0000;
    end else if (v < -34'sd1073741824) begin
      r = 32'hC000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // angle reduction into quadrant and cordic start angle
  logic signed [17:0] ang, a0;
  logic [15:0]        a1, rem;
  logic [1:0]         q;
  logic [31:0]        z_init;

  always_comb begin
    case (ang_sel)
      2'd0:    ang = 18'(roll);
      2'd1:    ang = 18'(pitch);
      default: ang = -18'(heading);
    endcase
    a0 = (ang < 0) ? ang + 18'sd72000 : ang;
    a1 = (a0 >= 18'sd36000) ? 16'(a0 - 18'sd36000) : 16'(a0);
    if (a1 >= 16'd27000) begin
      q = 2'd3; rem = a1 - 16'd27000;
    end else if (a1 >= 16'd18000) begin
      q = 2'd2; rem = a1 - 16'd18000;
    end else if (a1 >= 16'd9000) begin
      q = 2'd1; rem = a1 - 16'd9000;
    end else begin
      q = 2'd0; rem = a1;
    end
    z_init = 32'(rem[13:0] * 18'd187403);
  end

  // one cordic micro-rotation
  logic signed [33:0] dx, dy;
  logic signed [32:0] at;
  assign dx = y >>> iter;
  assign dy = x >>> iter;
  assign at = $signed({1'b0, atan_q30(5'(iter))});

  // quadrant mapping of clamped cos/sin
  logic [31:0] cc, ss, cmap, smap;
  always_comb begin
    cc = clamp30(x);
    ss = clamp30(y);
    case (quad)
      2'd0:    begin cmap = cc;  smap = ss;  end
      2'd1:    begin cmap = -ss; smap = cc;  end
      2'd2:    begin cmap = -cc; smap = -ss; end
      default: begin cmap = ss;  smap = -cc; end
    endcase
  end

  // matrix sequencer operands
  mstep_t             ms;
  logic signed [31:0] opv [9];
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] mul_rnd;
  logic signed [33:0] pn;

  always_comb begin
    ms          = mstep(step);
    opv[OP_CP]  = $signed(cosv[0]);
    opv[OP_SP]  = $signed(sinv[0]);
    opv[OP_CO]  = $signed(cosv[1]);
    opv[OP_SO]  = $signed(sinv[1]);
    opv[OP_CK]  = $signed(cosv[2]);
    opv[OP_SK]  = $signed(sinv[2]);
    opv[OP_T1]  = t1;
    opv[OP_T2]  = t2;
    opv[OP_ONE] = ONE;
    op_a        = opv[ms.a];
    op_b        = opv[ms.b];
    mul_rnd     = op_a * op_b + 64'sd536870912;
    pn          = ms.neg ? -34'(prod) : 34'(prod);
  end

  always_comb begin
    state_next = state;
    case (state)
      BLD_IDLE:   state_next = BLD_IDLE;
      BLD_REDUCE: state_next = BLD_ROT;
      BLD_ROT:    if (iter == IW'(CORDIC_STAGES - 1)) state_next = BLD_MAP;
      BLD_MAP:    state_next = (ang_sel == ANG_HEAD) ? BLD_MUL : BLD_REDUCE;
      BLD_MUL:    state_next = BLD_ACC;
      BLD_ACC:    state_next = (step == 4'(MSTEP_LAST)) ? BLD_IDLE : BLD_MUL;
      default:    state_next = BLD_IDLE;
    endcase
    if (angle_wr) state_next = BLD_REDUCE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BLD_REDUCE;
      ang_sel <= '0;
      current <= 1'b0;
      roll    <= '0;
      pitch   <= '0;
      heading <= '0;
    end else begin
      state <= state_next;
      if (wr_en && wr_index == REG_ROLL)    roll    <= wr_data[ANGLE_W-1:0];
      if (wr_en && wr_index == REG_PITCH)   pitch   <= wr_data[ANGLE_W-1:0];
      if (wr_en && wr_index == REG_HEADING) heading <= wr_data[ANGLE_W-1:0];
      if (angle_wr) begin
        ang_sel <= '0;
        current <= 1'b0;
      end else begin
        if (state == BLD_MAP && ang_sel != ANG_HEAD) ang_sel <= ang_sel + 1'b1;
        if (state == BLD_ACC && step == 4'(MSTEP_LAST)) current <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BLD_REDUCE: begin
        x    <= GAIN;
        y    <= '0;
        z    <= $signed({1'b0, z_init});
        quad <= q;
        iter <= '0;
      end
      BLD_ROT: begin
        if (!z[32]) begin
          x <= x - dx; y <= y + dy; z <= z - at;
        end else begin
          x <= x + dx; y <= y - dy; z <= z + at;
        end
        iter <= iter + 1'b1;
      end
      BLD_MAP: begin
        cosv[ang_sel] <= cmap;
        sinv[ang_sel] <= smap;
        step          <= '0;
      end
      BLD_MUL: begin
        prod <= 33'(mul_rnd >>> 30);
      end
      BLD_ACC: begin
        case (ms.kind)
          MK_TMP:  if (ms.dst[0]) t2 <= 32'(prod); else t1 <= 32'(prod);
          MK_LOAD: acc <= pn;
          MK_SUM:  coeffs[ms.dst] <= clamp30(acc + pn);
          default: coeffs[ms.dst] <= clamp30(pn);
        endcase
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/ertp_back.sv
// point pipeline: matrix multiply, rounding, offset, saturation and result queue
`default_nettype none
module ertp_back
  import ertp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  input  coeff_mat_t                 coeffs,
  input  wire logic                  in_valid,
  input  point_t                     in_point,
  output logic                       in_pop,
  input  wire logic                  pop,
  output logic                       empty,
  output result_t                    result
);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic signed [COORD_W-1:0] off [3];
  logic signed [63:0]        prod [3][3];
  logic signed [33:0]        rowv [3];
  logic                      v1, v2;
  logic [CW-1:0]             out_count;
  logic [CW:0]               occ;
  logic signed [COORD_W-1:0] pc [3];
  result_t                   res;
  logic                      out_full;

  assign pc[0] = $signed(in_point.x);
  assign pc[1] = $signed(in_point.y);
  assign pc[2] = $signed(in_point.z);

  // reserve result queue space for everything in flight
  assign occ    = (CW+1)'(out_count) + (CW+1)'(v1) + (CW+1)'(v2);
  assign in_pop = in_valid && (occ < (CW+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      off[0] <= '0;
      off[1] <= '0;
      off[2] <= '0;
    end else begin
      v1 <= in_pop;
      v2 <= v1;
      if (wr_en && wr_index == REG_OFFSET_X) off[0] <= wr_data;
      if (wr_en && wr_index == REG_OFFSET_Y) off[1] <= wr_data;
      if (wr_en && wr_index == REG_OFFSET_Z) off[2] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] <= $signed(coeffs[r*3+c]) * pc[c];
      end
      rowv[r] <= 34'((prod[r][0] + prod[r][1] + prod[r][2] + 64'sd536870912) >>> 30);
    end
  end

  logic signed [34:0] tsum [3];
  logic [COORD_W-1:0] sv [3];
  logic [2:0]         clip;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tsum[r] = 35'(rowv[r]) + 35'(off[r]);
      clip[r] = 1'b1;
      if (tsum[r] > 35'sd2147483647) begin
        sv[r] = 32'h7FFF_FFFF;
      end else if (tsum[r] < -35'sd2147483648) begin
        sv[r] = 32'h8000_0000;
      end else begin
        sv[r]   = tsum[r][31:0];
        clip[r] = 1'b0;
      end
    end
    res.x   = sv[0];
    res.y   = sv[1];
    res.z   = sv[2];
    res.sat = |clip;
  end

  ertp_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (v2),
    .din  (res),
    .pop  (pop),
    .dout (result),
    .empty(empty),
    .full (out_full),
    .count(out_count)
  );

  // space is reserved at issue, so the queue never refuses a push
  logic unused_full;
  assign unused_full = out_full;
endmodule
`default_nettype wire

>>> hw/rtl/euler_rotate_translate_point.sv
// top level: rigid 3-d transform of sensor-frame points into the global frame
//
// Input channel: drive point_x/y/z and push; a transaction completes on a
// clock edge with push high and full low. Results: while empty is low the
// oldest result sits on out_x/y/z and saturated; pop with empty low takes it.
// Configuration: wr_en, wr_index, wr_data write one register per cycle
// (roll, pitch, heading, offset x/y/z); write only while no point is pending.
// An angle write makes the block rebuild its rotation matrix: full stays high
// while one shared cordic unit and one multiplier step through the three
// angles and the nine entries. The same happens straight after reset, so
// full is high then too. Offset writes take effect at once and keep the
// matrix. Once the matrix is built, one point is taken per cycle while the
// result queue has room; a result passes the input queue, the product stage
// and the row-sum stage (the result queue falls through). Nine 32x32
// multipliers in parallel set that rate. When the receiver stalls, the
// result queue fills, issue stops and the input queue absorbs up to four
// more points before full rises.
`default_nettype none
module euler_rotate_translate_point
  import ertp_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  input  wire logic [COORD_W-1:0]    point_x,
  input  wire logic [COORD_W-1:0]    point_y,
  input  wire logic [COORD_W-1:0]    point_z,
  input  wire logic                  push,
  output logic                       full,
  output logic [COORD_W-1:0]         out_x,
  output logic [COORD_W-1:0]         out_y,
  output logic [COORD_W-1:0]         out_z,
  output logic                       saturated,
  output logic                       empty,
  input  wire logic                  pop
);
  coeff_mat_t                      coeffs;
  logic                            current;
  point_t                          in_pt, mid_pt;
  logic                            mid_empty, mid_full, mid_pop;
  logic [$clog2(MID_DEPTH+1)-1:0]  mid_count;
  result_t                         res;

  assign in_pt = '{z: point_z, y: point_y, x: point_x};
  // points are held off until the matrix is current
  assign full  = mid_full || !current;

  ertp_build #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_build (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .coeffs  (coeffs),
    .current (current)
  );

  ertp_fifo #(
    .WIDTH($bits(point_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && !full),
    .din  (in_pt),
    .pop  (mid_pop),
    .dout (mid_pt),
    .empty(mid_empty),
    .full (mid_full),
    .count(mid_count)
  );

  ertp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .coeffs  (coeffs),
    .in_valid(!mid_empty && mid_count != '0),
    .in_point(mid_pt),
    .in_pop  (mid_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (res)
  );

  assign out_x     = res.x;
  assign out_y     = res.y;
  assign out_z     = res.z;
  assign saturated = res.sat;
endmodule
`default_nettype wire

>>> hw/rtl/ertp_checker.sv
// port-level checks for the euler rotate/translate point block
`default_nettype none
module ertp_checker
  import ertp_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 wr_en,
  input wire logic [CFG_IDX_W-1:0] wr_index,
  input wire logic                 full,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire logic [COORD_W-1:0]   out_x,
  input wire logic [COORD_W-1:0]   out_y,
  input wire logic [COORD_W-1:0]   out_z,
  input wire logic                 saturated
);
  // matrix is stale after reset, so nothing may be taken and nothing shown
  a_reset_state: assert property (@(posedge clk) rst |=> full && empty)
    else $error("block not held off after reset");

  a_angle_rebuild: assert property (@(posedge clk) disable iff (rst)
    wr_en && (wr_index == REG_ROLL || wr_index == REG_PITCH ||
              wr_index == REG_HEADING) |=> full)
    else $error("input taken while matrix rebuild pending");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    !empty && saturated |->
      (out_x == 32'h7FFF_FFFF || out_x == 32'h8000_0000 ||
       out_y == 32'h7FFF_FFFF || out_y == 32'h8000_0000 ||
       out_z == 32'h7FFF_FFFF || out_z == 32'h8000_0000))
    else $error("saturation flag without a clamped coordinate");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_x) && $stable(out_y) &&
                      $stable(out_z) && $stable(saturated))
    else $error("waiting result changed");
endmodule

bind euler_rotate_translate_point ertp_checker u_ertp_checker (.*);
`default_nettype wire

>>> verif/tb_euler_rotate_translate_point.sv
// testbench for euler_rotate_translate_point: directed table, then random phases
`default_nettype none
module tb_euler_rotate_translate_point;
  import ertp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam longint Q_ONE  = 64'sd1073741824;
  localparam longint Q_HALF = 64'sd536870912;
  localparam longint GAIN   = 64'sd652032874;
  localparam longint CDEG_RAD = 64'sd187403;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam int     N_PHASES = 15;
  localparam int     PHASE_LEN = 102;

  localparam longint ATAN_TBL [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000};

  logic clk, rst, wr_en, push, pop;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;
  logic [COORD_W-1:0]    point_x, point_y, point_z;
  logic                  full, empty, saturated;
  logic [COORD_W-1:0]    out_x, out_y, out_z;

  euler_rotate_translate_point i_dut (
    .clk, .rst, .wr_en, .wr_index, .wr_data, .point_x, .point_y, .point_z,
    .push, .full, .out_x, .out_y, .out_z, .saturated, .empty, .pop
  );

  // predictor state
  longint  ang_roll, ang_pitch, ang_head, off_x, off_y, off_z;
  longint  rot [9];
  bit      rot_valid;
  result_t pending_q [$];
  int      mismatches;
  bit      no_idle;

  typedef struct {
    bit                    is_wr;
    logic [CFG_IDX_W-1:0]  idx;
    logic [31:0]           data;
    logic [31:0]           x, y, z;
    bit                    chk;
    logic [31:0]           ex, ey, ez;
    bit                    esat;
  } step_row_t;

  localparam logic [31:0] MAXV = 32'h7FFFFFFF;
  localparam logic [31:0] MINV = 32'h80000000;

  step_row_t dir_tbl [] = '{
    '{0, REG_ROLL, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{0, REG_ROLL, 0, MAXV, MAXV, MAXV, 0, 0, 0, 0, 0},
    '{0, REG_ROLL, 0, MINV, MINV, MINV, 0, 0, 0, 0, 0},
    '{0, REG_ROLL, 0, 1, 32'hFFFFFFFF, 5, 1, 1, 32'hFFFFFFFF, 5, 0},
    '{1, REG_OFFSET_X, MAXV, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, REG_OFFSET_Y, MINV, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, REG_OFFSET_Z, 32'd1000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, REG_ROLL, 0, 0, 0, 0, 1, MAXV, MINV, 32'd1000, 0},
    '{0, REG_ROLL, 0, 1, 32'hFFFFFFFF, MAXV, 0, 0, 0, 0, 0},
    '{1, REG_UNUSED, 32'h12345, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, REG_ROLL, 0, 5, 6, 7, 1, MAXV, 32'h80000006, 32'd1007, 1},
    '{1, REG_ROLL, 32'd9000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, REG_PITCH, -32'sd9000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, REG_HEADING, 32'd18000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, REG_ROLL, 0, 32'd123456, 32'hFFF00000, 32'd777, 0, 0, 0, 0, 0},
    '{1, REG_ROLL, 32'h0FFFF, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, REG_PITCH, 32'h10000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, REG_HEADING, 32'd36000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, REG_ROLL, 0, MAXV, MINV, 32'd42, 0, 0, 0, 0, 0},
    '{1, REG_OFFSET_X, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, REG_ROLL, 0, 32'd1000000, 32'd2000000, 32'hFFFFFF00, 0, 0, 0, 0, 0}
  };

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint qprod(longint a, longint b);
    return (a * b + Q_HALF) >>> 30;
  endfunction

  function automatic void cordic_sin_cos(input longint ang, output longint c, output longint s);
    longint a, q, r, x, y, z, dx, dy, cc, ss;
    a = ang % 36000;
    if (a < 0) a += 36000;
    q = a / 9000;
    r = a - q * 9000;
    x = GAIN;
    y = 0;
    z = r * CDEG_RAD;
    for (int i = 0; i < CORDIC_STAGES_DEF && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    cc = clip(x, -Q_ONE, Q_ONE);
    ss = clip(y, -Q_ONE, Q_ONE);
    case (q)
      0: begin c = cc;  s = ss;  end
      1: begin c = -ss; s = cc;  end
      2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endfunction

  function automatic void rebuild_rotation();
    longint cp, sp, co, so, ck, sk, m [9];
    cordic_sin_cos(ang_roll, cp, sp);
    cordic_sin_cos(ang_pitch, co, so);
    cordic_sin_cos(-ang_head, ck, sk);
    m[0] = qprod(cp, ck) - qprod(qprod(sp, so), sk);
    m[1] = -qprod(cp, sk) - qprod(qprod(sp, so), ck);
    m[2] = -qprod(sp, co);
    m[3] = qprod(co, sk);
    m[4] = qprod(co, ck);
    m[5] = -so;
    m[6] = qprod(sp, ck) + qprod(qprod(cp, so), sk);
    m[7] = -qprod(sp, sk) + qprod(qprod(cp, so), ck);
    m[8] = qprod(cp, co);
    for (int k = 0; k < 9; k++) rot[k] = clip(m[k], -Q_ONE, Q_ONE);
    rot_valid = 1;
  endfunction

  function automatic result_t transform_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    longint  p [3], offs [3], acc, t;
    logic [31:0] o [3];
    result_t r;
    p[0] = longint'($signed(x));
    p[1] = longint'($signed(y));
    p[2] = longint'($signed(z));
    offs[0] = off_x; offs[1] = off_y; offs[2] = off_z;
    if (!rot_valid) rebuild_rotation();
    r.sat = 0;
    for (int row = 0; row < 3; row++) begin
      acc = rot[row*3] * p[0] + rot[row*3+1] * p[1] + rot[row*3+2] * p[2];
      t = ((acc + Q_HALF) >>> 30) + offs[row];
      if (t > I32_MAX) begin t = I32_MAX; r.sat = 1; end
      if (t < I32_MIN) begin t = I32_MIN; r.sat = 1; end
      o[row] = t[31:0];
    end
    r.x = o[0]; r.y = o[1]; r.z = o[2];
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("euler_rotate_translate_point verification failed");
    $finish;
  end

  // accepted transactions on both sides
  always @(posedge clk) begin
    result_t want;
    if (!rst && push && !full)
      pending_q.push_back(transform_point(point_x, point_y, point_z));
    if (!rst && pop && !empty) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h %b", out_x, out_y, out_z, saturated);
      end else begin
        want = pending_q.pop_front();
        if (want.x !== out_x || want.y !== out_y || want.z !== out_z || want.sat !== saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h %b got %h %h %h %b", want.x, want.y, want.z,
                     want.sat, out_x, out_y, out_z, saturated);
        end
      end
    end
  end

  // receiver with random stalls
  initial begin
    int gap;
    pop = 0;
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        pop = 0;
        repeat (gap) @(negedge clk);
      end
      pop = 1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      push = 0;
      repeat (gap) @(negedge clk);
    end
    point_x = x; point_y = y; point_z = z;
    push = 1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    push = 0;
    wait (pending_q.size() == 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    wr_en = 1; wr_index = idx; wr_data = data;
    case (idx)
      REG_ROLL:     begin ang_roll  = longint'($signed(data[16:0])); rot_valid = 0; end
      REG_PITCH:    begin ang_pitch = longint'($signed(data[16:0])); rot_valid = 0; end
      REG_HEADING:  begin ang_head  = longint'($signed(data[16:0])); rot_valid = 0; end
      REG_OFFSET_X: off_x = longint'($signed(data));
      REG_OFFSET_Y: off_y = longint'($signed(data));
      REG_OFFSET_Z: off_z = longint'($signed(data));
      default: ;
    endcase
    @(negedge clk);
    wr_en = 0;
  endtask

  function automatic logic [31:0] rand_angle(bit extreme);
    logic [31:0] picks [5] = '{-32'sd36000, 32'd36000, 32'd0, 32'h0FFFF, 32'h10000};
    if (extreme) return picks[$urandom_range(0, 4)];
    if ($urandom_range(0, 1)) return $urandom();
    return $urandom_range(0, 72000) - 36000;
  endfunction

  function automatic logic [31:0] rand_offset(bit extreme);
    if (extreme) return $urandom_range(0, 1) ? MAXV : MINV;
    if ($urandom_range(0, 2) == 0) return $urandom();
    return $urandom_range(0, 20000000) - 10000000;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 2000000) - 1000000;
  endfunction

  initial begin
    step_row_t row;
    bit ext;
    rst = 1; wr_en = 0; wr_index = REG_ROLL; wr_data = 0; push = 0;
    point_x = 0; point_y = 0; point_z = 0;
    ang_roll = 0; ang_pitch = 0; ang_head = 0; off_x = 0; off_y = 0; off_z = 0;
    for (int k = 0; k < 9; k++) rot[k] = (k % 4 == 0) ? Q_ONE : 0;
    rot_valid = 0;
    mismatches = 0;
    no_idle = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      if (row.is_wr) begin
        drain();
        write_reg(row.idx, row.data);
      end else begin
        if (row.chk && transform_point(row.x, row.y, row.z) !==
            result_t'{row.esat, row.ez, row.ey, row.ex}) begin
          mismatches++;
          if (mismatches <= 10) $display("directed row %0d disagrees with prediction", i);
        end
        send_point(row.x, row.y, row.z);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      ext = (ph % 5 == 0);
      no_idle = (ph % 4 == 2);
      if (ph % 3 != 1) begin
        write_reg(REG_ROLL, rand_angle(ext));
        write_reg(REG_PITCH, rand_angle(ext));
        write_reg(REG_HEADING, rand_angle(ext));
      end
      write_reg(REG_OFFSET_X, rand_offset(ext));
      write_reg(REG_OFFSET_Y, rand_offset(ext));
      write_reg(REG_OFFSET_Z, rand_offset(ext));
      for (int n = 0; n < PHASE_LEN; n++) begin
        // in phase 3, before point 50, the sender holds off until the result queue is empty
        if (ph == 3 && n == 50) drain();
        send_point(rand_coord(), rand_coord(), rand_coord());
      end
    end

    @(negedge clk);
    push = 0;
    fork
      wait (pending_q.size() == 0);
      repeat (100000) @(posedge clk);
    join_any
    disable fork;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("euler_rotate_translate_point verification clean");
    else
      $display("euler_rotate_translate_point verification failed");
    $finish;
  end

endmodule
`default_nettype wire
